// ----- design/fp32_elementwise_alu_defines.svh -----
// ----------------------------------------------------------------------------
// FP32 element-wise ALU assertion macros
// Clocked assertion wrappers used by the top-level design file; they compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FP32_ELEMENTWISE_ALU_DEFINES_SVH
`define FP32_ELEMENTWISE_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define FPEA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FPEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FPEA_ASSERT(lbl, prop, msg)
`define FPEA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/fpea_pkg.sv -----
// ----------------------------------------------------------------------------
// FP32 element-wise ALU package
// Operation and register codes, pipeline lengths and shared rounding helpers.
// ----------------------------------------------------------------------------
package fpea_pkg;

    localparam logic [2:0] OP_ADDS = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MAX  = 3'd3;
    localparam logic [2:0] OP_MUL  = 3'd4;
    localparam logic [2:0] OP_RSQ  = 3'd5;
    localparam logic [2:0] OP_RSV6 = 3'd6;
    localparam logic [2:0] OP_RSV7 = 3'd7;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALAR  = 2'd1;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

    localparam int ADD_LAT  = 6;
    localparam int MUL_LAT  = 6;
    localparam int SQ_STEPS = 25;
    localparam int DV_STEPS = 25;
    localparam int RSQ_LAT  = 4 + SQ_STEPS + DV_STEPS;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] c;
        c = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) c = 6'(47 - i);
        end
        return c;
    endfunction

    // Round to nearest even and pack; exp is the biased exponent, at least one.
    function automatic logic [31:0] round_pack(input logic sgn, input logic [9:0] exp,
                                               input logic [23:0] man, input logic grd,
                                               input logic stk);
        logic        inc;
        logic [24:0] sum;
        logic [9:0]  e;
        logic [23:0] m;
        logic [31:0] r;
        inc = grd & (stk | man[0]);
        sum = {1'b0, man} + {24'd0, inc};
        if (sum[24]) begin
            m = 24'h80_0000;
            e = exp + 10'd1;
        end else begin
            m = sum[23:0];
            e = exp;
        end
        if (e >= 10'd255) r = {sgn, INF_MAG};
        else if (!m[23]) r = {sgn, 8'd0, m[22:0]};
        else r = {sgn, e[7:0], m[22:0]};
        return r;
    endfunction

endpackage

// ----- design/fpea_if.sv -----
// ----------------------------------------------------------------------------
// FP32 element-wise ALU channel interfaces
// Operand, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpea_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    modport source(output valid, operand_a, operand_b, input ready);
    modport sink(input valid, operand_a, operand_b, output ready);
endinterface

interface fpea_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    modport source(output valid, result_value, input ready);
    modport sink(input valid, result_value, output ready);
endinterface

interface fpea_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fpea_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- design/fp32_elementwise_alu.sv -----
// ----------------------------------------------------------------------------
// FP32 element-wise ALU
// Streams pairs of fp32 tensor elements through add, subtract, max, multiply
// or reciprocal square root, selected by a mode register.
// ----------------------------------------------------------------------------
// Usage: operand words enter on din (operand_a, operand_b) and result words
// leave on dout (result_value), both with valid/ready. Registers are written
// on cfg: index 0 is op_mode, index 1 is scalar_addend; other indices are
// ignored. cfg is always ready and should only be written while the unit is
// empty.
// Every word passes through one common pipeline whose length is set by the
// reciprocal square root: one stage per root bit and one per quotient bit.
// One word is accepted every cycle while dout is being drained.
// Reset clears all valid bits and sets op_mode to add and the scalar to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and din.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "fp32_elementwise_alu_defines.svh"

module fp32_elementwise_alu (
    input  logic             clk,
    input  logic             rst_n,
    fpea_cfg_if.sink         cfg,
    fpea_in_if.sink          din,
    fpea_out_if.source       dout
);

    localparam int LAT = fpea_pkg::RSQ_LAT;
    localparam int ADL = fpea_pkg::RSQ_LAT - fpea_pkg::ADD_LAT;
    localparam int MDL = fpea_pkg::RSQ_LAT - fpea_pkg::MUL_LAT;

    logic [2:0]  op_mode_reg;
    logic [31:0] scalar_reg;
    logic        vld_reg     [LAT];
    logic [2:0]  mode_reg    [LAT];
    logic [31:0] max_dly_reg [LAT];
    logic [31:0] add_dly_reg [ADL];
    logic [31:0] mul_dly_reg [MDL];
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic        advance;
    logic [31:0] b_eff;
    logic [31:0] add_res, mul_res, rsq_res;
    logic        a_lt_b;
    logic [31:0] res_next;

    function automatic logic fp_lt(input logic [31:0] x, input logic [31:0] y);
        logic lt;
        if ((x[30:0] > fpea_pkg::INF_MAG) || (y[30:0] > fpea_pkg::INF_MAG)) lt = 1'b0;
        else if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)) lt = 1'b0;
        else if (x[31] != y[31]) lt = x[31];
        else if (!x[31]) lt = x[30:0] < y[30:0];
        else lt = x[30:0] > y[30:0];
        return lt;
    endfunction

    assign advance   = !out_valid_reg || dout.ready;
    assign din.ready = advance;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        case (op_mode_reg)
            fpea_pkg::OP_ADDS: b_eff = scalar_reg;
            fpea_pkg::OP_SUB:  b_eff = {~din.operand_b[31], din.operand_b[30:0]};
            default:           b_eff = din.operand_b;
        endcase
        a_lt_b = fp_lt(din.operand_a, din.operand_b);
    end

    fpea_add u_add (
        .clk (clk),
        .en  (advance),
        .a   (din.operand_a),
        .b   (b_eff),
        .sum (add_res)
    );

    fpea_mul u_mul (
        .clk  (clk),
        .en   (advance),
        .a    (din.operand_a),
        .b    (din.operand_b),
        .prod (mul_res)
    );

    fpea_rsqrt u_rsqrt (
        .clk (clk),
        .en  (advance),
        .a   (din.operand_a),
        .res (rsq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg <= fpea_pkg::OP_ADD;
            scalar_reg  <= 32'd0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                fpea_pkg::CFG_OP_MODE: op_mode_reg <= cfg.data[2:0];
                fpea_pkg::CFG_SCALAR:  scalar_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= din.valid;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode_reg[0]    <= op_mode_reg;
            max_dly_reg[0] <= a_lt_b ? din.operand_b : din.operand_a;
            for (int i = 1; i < LAT; i++)
            begin
                mode_reg[i]    <= mode_reg[i-1];
                max_dly_reg[i] <= max_dly_reg[i-1];
            end
            add_dly_reg[0] <= add_res;
            for (int i = 1; i < ADL; i++) add_dly_reg[i] <= add_dly_reg[i-1];
            mul_dly_reg[0] <= mul_res;
            for (int i = 1; i < MDL; i++) mul_dly_reg[i] <= mul_dly_reg[i-1];
            out_data_reg <= res_next;
        end
    end

    always_comb
    begin
        case (mode_reg[LAT-1]) inside
            fpea_pkg::OP_ADDS, fpea_pkg::OP_ADD, fpea_pkg::OP_SUB:
                res_next = add_dly_reg[ADL-1];
            fpea_pkg::OP_MAX: res_next = max_dly_reg[LAT-1];
            fpea_pkg::OP_MUL: res_next = mul_dly_reg[MDL-1];
            fpea_pkg::OP_RSQ: res_next = rsq_res;
            default:          res_next = 32'd0;
        endcase
    end

    assign dout.valid        = out_valid_reg;
    assign dout.result_value = out_data_reg;

    `FPEA_ASSERT(a_nan_canonical, (vld_reg[LAT-1] && mode_reg[LAT-1] != fpea_pkg::OP_MAX && res_next[30:23] == 8'hFF && res_next[22:0] != 23'd0) |-> res_next == fpea_pkg::CANON_NAN, "arithmetic NaN result is not canonical")
    `FPEA_ASSERT(a_rsqrt_sign, (vld_reg[LAT-1] && mode_reg[LAT-1] == fpea_pkg::OP_RSQ && res_next[31]) |-> (res_next == fpea_pkg::CANON_NAN || res_next == 32'hFF80_0000), "negative reciprocal square root result")
    `FPEA_ASSERT(a_unused_zero, (mode_reg[LAT-1] == fpea_pkg::OP_RSV6 || mode_reg[LAT-1] == fpea_pkg::OP_RSV7) |-> res_next == 32'd0, "unused mode gave a nonzero word")
    `FPEA_ASSERT_NEXT(a_cfg_mode, cfg.valid && cfg.ready && cfg.index == fpea_pkg::CFG_OP_MODE, op_mode_reg == $past(cfg.data[2:0]), "op_mode write not taken")

endmodule

// ----- design/fpea_add.sv -----
// ----------------------------------------------------------------------------
// FP32 adder
// Six-stage pipelined IEEE-754 single-precision adder, round to nearest even.
// ----------------------------------------------------------------------------
module fpea_add (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] sum
);

    typedef struct packed {
        logic nan;
        logic inf;
        logic isgn;
        logic zsgn;
        logic sgn;
    } add_side_t;

    localparam logic [30:0] INF_MAG_C = fpea_pkg::INF_MAG;

    logic [30:0] a_mag, b_mag;
    logic        swap;
    logic [31:0] big, sml;
    add_side_t   side_next;

    add_side_t   s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg, s5_side_reg;
    logic        s1_sub_reg, s2_sub_reg;
    logic [7:0]  s1_exp_reg, s2_exp_reg, s3_exp_reg, s4_exp_reg;
    logic [23:0] s1_mbig_reg, s1_msml_reg;
    logic [7:0]  s1_d_reg;
    logic [26:0] s2_mb_reg, s2_ms_reg;
    logic [27:0] s3_sum_reg, s4_sum_reg;
    logic        s4_rsh_reg, s4_zero_reg, s5_zero_reg;
    logic [5:0]  s4_lsh_reg;
    logic [9:0]  s5_exp_reg;
    logic [23:0] s5_man_reg;
    logic        s5_grd_reg, s5_stk_reg;
    logic [31:0] sum_reg;

    logic [7:0]  big_e, sml_e;
    logic [4:0]  dcap;
    logic [53:0] al_sh;
    logic [26:0] al;
    logic [5:0]  lz, lsh;
    logic [7:0]  exp_m1;
    logic [26:0] nrm;
    logic [9:0]  nexp;

    always_comb
    begin
        a_mag = a[30:0];
        b_mag = b[30:0];
        swap  = b_mag > a_mag;
        big   = swap ? b : a;
        sml   = swap ? a : b;
        big_e = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        sml_e = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        side_next.nan  = (a_mag > INF_MAG_C) || (b_mag > INF_MAG_C) ||
                         ((a_mag == INF_MAG_C) && (b_mag == INF_MAG_C) && (a[31] ^ b[31]));
        side_next.inf  = (a_mag == INF_MAG_C) || (b_mag == INF_MAG_C);
        side_next.isgn = (a_mag == INF_MAG_C) ? a[31] : b[31];
        side_next.zsgn = a[31] & b[31];
        side_next.sgn  = big[31];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= side_next;
            s1_sub_reg  <= a[31] ^ b[31];
            s1_exp_reg  <= big_e;
            s1_mbig_reg <= {big[30:23] != 8'd0, big[22:0]};
            s1_msml_reg <= {sml[30:23] != 8'd0, sml[22:0]};
            s1_d_reg    <= big_e - sml_e;
        end
    end

    always_comb
    begin
        dcap  = (s1_d_reg > 8'd27) ? 5'd27 : s1_d_reg[4:0];
        al_sh = {s1_msml_reg, 30'd0} >> dcap;
        al    = {al_sh[53:28], al_sh[27] | (|al_sh[26:0])};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg <= s1_side_reg;
            s2_sub_reg  <= s1_sub_reg;
            s2_exp_reg  <= s1_exp_reg;
            s2_mb_reg   <= {s1_mbig_reg, 3'd0};
            s2_ms_reg   <= al;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s2_side_reg;
            s3_exp_reg  <= s2_exp_reg;
            s3_sum_reg  <= s2_sub_reg ? ({1'b0, s2_mb_reg} - {1'b0, s2_ms_reg})
                                      : ({1'b0, s2_mb_reg} + {1'b0, s2_ms_reg});
        end
    end

    always_comb
    begin
        lz     = fpea_pkg::lzc48({s3_sum_reg[26:0], 21'd0});
        exp_m1 = s3_exp_reg - 8'd1;
        lsh    = ({2'd0, lz} > exp_m1) ? exp_m1[5:0] : lz;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s3_side_reg;
            s4_exp_reg  <= s3_exp_reg;
            s4_sum_reg  <= s3_sum_reg;
            s4_rsh_reg  <= s3_sum_reg[27];
            s4_lsh_reg  <= lsh;
            s4_zero_reg <= s3_sum_reg == 28'd0;
        end
    end

    always_comb
    begin
        if (s4_rsh_reg)
        begin
            nrm  = {s4_sum_reg[27:2], s4_sum_reg[1] | s4_sum_reg[0]};
            nexp = {2'd0, s4_exp_reg} + 10'd1;
        end
        else
        begin
            nrm  = s4_sum_reg[26:0] << s4_lsh_reg;
            nexp = {2'd0, s4_exp_reg} - {4'd0, s4_lsh_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= s4_side_reg;
            s5_zero_reg <= s4_zero_reg;
            s5_exp_reg  <= nexp;
            s5_man_reg  <= nrm[26:3];
            s5_grd_reg  <= nrm[2];
            s5_stk_reg  <= nrm[1] | nrm[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s5_side_reg.nan) sum_reg <= fpea_pkg::CANON_NAN;
            else if (s5_side_reg.inf) sum_reg <= {s5_side_reg.isgn, INF_MAG_C};
            else if (s5_zero_reg) sum_reg <= {s5_side_reg.zsgn, 31'd0};
            else sum_reg <= fpea_pkg::round_pack(s5_side_reg.sgn, s5_exp_reg, s5_man_reg,
                                                 s5_grd_reg, s5_stk_reg);
        end
    end

    assign sum = sum_reg;

endmodule

// ----- design/fpea_mul.sv -----
// ----------------------------------------------------------------------------
// FP32 multiplier
// Six-stage pipelined IEEE-754 single-precision multiplier with subnormals.
// ----------------------------------------------------------------------------
module fpea_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] prod
);

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sgn;
    } mul_side_t;

    localparam logic [30:0] INF_MAG_C = fpea_pkg::INF_MAG;

    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    mul_side_t   side_next;

    mul_side_t   s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg, s5_side_reg;
    logic [7:0]  s1_ea_reg, s1_eb_reg;
    logic [23:0] s1_ma_reg, s1_mb_reg;
    logic [47:0] s2_p_reg, s3_p_reg, s4_p_reg;
    logic signed [9:0] s2_e0_reg, s3_e0_reg;
    logic [5:0]  s3_lz_reg;
    logic        s4_right_reg;
    logic [5:0]  s4_amt_reg;
    logic [9:0]  s4_e_reg, s5_e_reg;
    logic [23:0] s5_man_reg;
    logic        s5_grd_reg, s5_stk_reg;
    logic [31:0] prod_reg;

    logic signed [9:0] e_minus, ramt;
    logic        right;
    logic [5:0]  amt;
    logic [9:0]  enext;
    logic [95:0] rsh;
    logic [47:0] q;
    logic        lost;

    always_comb
    begin
        a_nan  = a[30:0] > INF_MAG_C;
        b_nan  = b[30:0] > INF_MAG_C;
        a_inf  = a[30:0] == INF_MAG_C;
        b_inf  = b[30:0] == INF_MAG_C;
        a_zero = a[30:0] == 31'd0;
        b_zero = b[30:0] == 31'd0;
        side_next.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
        side_next.inf  = a_inf | b_inf;
        side_next.zero = a_zero | b_zero;
        side_next.sgn  = a[31] ^ b[31];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= side_next;
            s1_ea_reg   <= (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
            s1_eb_reg   <= (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
            s1_ma_reg   <= {a[30:23] != 8'd0, a[22:0]};
            s1_mb_reg   <= {b[30:23] != 8'd0, b[22:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg <= s1_side_reg;
            s2_p_reg    <= s1_ma_reg * s1_mb_reg;
            s2_e0_reg   <= $signed({2'd0, s1_ea_reg} + {2'd0, s1_eb_reg} - 10'd126);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s2_side_reg;
            s3_p_reg    <= s2_p_reg;
            s3_e0_reg   <= s2_e0_reg;
            s3_lz_reg   <= fpea_pkg::lzc48(s2_p_reg);
        end
    end

    always_comb
    begin
        e_minus = s3_e0_reg - $signed({4'd0, s3_lz_reg});
        ramt    = 10'sd1 - s3_e0_reg;
        if (e_minus >= 10'sd1)
        begin
            right = 1'b0;
            amt   = s3_lz_reg;
            enext = e_minus;
        end
        else if (s3_e0_reg >= 10'sd1)
        begin
            right = 1'b0;
            amt   = 6'(s3_e0_reg - 10'sd1);
            enext = 10'd1;
        end
        else
        begin
            right = 1'b1;
            amt   = (ramt > 10'sd63) ? 6'd63 : ramt[5:0];
            enext = 10'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg  <= s3_side_reg;
            s4_p_reg     <= s3_p_reg;
            s4_right_reg <= right;
            s4_amt_reg   <= amt;
            s4_e_reg     <= enext;
        end
    end

    always_comb
    begin
        rsh = {s4_p_reg, 48'd0} >> s4_amt_reg;
        if (s4_right_reg)
        begin
            q    = rsh[95:48];
            lost = |rsh[47:0];
        end
        else
        begin
            q    = s4_p_reg << s4_amt_reg;
            lost = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= s4_side_reg;
            s5_e_reg    <= s4_e_reg;
            s5_man_reg  <= q[47:24];
            s5_grd_reg  <= q[23];
            s5_stk_reg  <= (|q[22:0]) | lost;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s5_side_reg.nan) prod_reg <= fpea_pkg::CANON_NAN;
            else if (s5_side_reg.inf) prod_reg <= {s5_side_reg.sgn, INF_MAG_C};
            else if (s5_side_reg.zero) prod_reg <= {s5_side_reg.sgn, 31'd0};
            else prod_reg <= fpea_pkg::round_pack(s5_side_reg.sgn, s5_e_reg, s5_man_reg,
                                                  s5_grd_reg, s5_stk_reg);
        end
    end

    assign prod = prod_reg;

endmodule

// ----- design/fpea_rsqrt.sv -----
// ----------------------------------------------------------------------------
// FP32 reciprocal square root
// Bit-per-stage square root, rounded to fp32, then a bit-per-stage
// reciprocal division, rounded again.
// ----------------------------------------------------------------------------
module fpea_rsqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    output logic [31:0] res
);

    typedef struct packed {
        logic        spec;
        logic [31:0] val;
    } rsq_side_t;

    localparam int SQ = fpea_pkg::SQ_STEPS;
    localparam int DV = fpea_pkg::DV_STEPS;
    localparam int SB = fpea_pkg::RSQ_LAT - 1;
    localparam logic [30:0] INF_MAG_C = fpea_pkg::INF_MAG;

    rsq_side_t   side_next;
    rsq_side_t   sb_reg [SB];

    logic [23:0] r1_m_reg;
    logic [7:0]  r1_ex_reg;
    logic [5:0]  r1_lz_reg;

    logic [50:0] sq_n_reg   [SQ+1];
    logic [50:0] sq_res_reg [SQ+1];
    logic [9:0]  sq_e_reg   [SQ+1];

    logic [24:0] dv_r_reg    [DV+1];
    logic [24:0] dv_quot_reg [DV+1];
    logic [23:0] dv_q_reg    [DV+1];
    logic [9:0]  dv_e_reg    [DV+1];

    logic [31:0] res_reg;

    logic [23:0] mn;
    logic signed [9:0] e, diff;
    logic [4:0]  s;
    logic [23:0] rq;
    logic        rinc;
    logic [24:0] rsum;

    always_comb
    begin
        side_next.spec = 1'b1;
        side_next.val  = fpea_pkg::CANON_NAN;
        if (a[30:0] > INF_MAG_C) side_next.val = fpea_pkg::CANON_NAN;
        else if (a[30:0] == 31'd0) side_next.val = {a[31], INF_MAG_C};
        else if (a[31]) side_next.val = fpea_pkg::CANON_NAN;
        else if (a[30:0] == INF_MAG_C) side_next.val = 32'd0;
        else side_next.spec = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= side_next;
            for (int i = 1; i < SB; i++) sb_reg[i] <= sb_reg[i-1];
            r1_m_reg  <= {a[30:23] != 8'd0, a[22:0]};
            r1_ex_reg <= a[30:23];
            r1_lz_reg <= fpea_pkg::lzc48({a[30:23] != 8'd0, a[22:0], 24'd0});
        end
    end

    always_comb
    begin
        mn = r1_m_reg << r1_lz_reg;
        if (r1_ex_reg == 8'd0) e = -10'sd149 - $signed({4'd0, r1_lz_reg});
        else e = $signed({2'd0, r1_ex_reg}) - 10'sd150;
        s    = e[0] ? 5'd25 : 5'd26;
        diff = e - $signed({5'd0, s});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_n_reg[0]   <= {27'd0, mn} << s;
            sq_res_reg[0] <= 51'd0;
            sq_e_reg[0]   <= 10'((diff >>> 1) + 10'sd151);
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sq
        localparam logic [50:0] BIT_C = 51'd1 << (48 - 2 * k);
        logic [50:0] trial;
        assign trial = sq_res_reg[k] + BIT_C;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_e_reg[k+1] <= sq_e_reg[k];
                if (sq_n_reg[k] >= trial)
                begin
                    sq_n_reg[k+1]   <= sq_n_reg[k] - trial;
                    sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + BIT_C;
                end
                else
                begin
                    sq_n_reg[k+1]   <= sq_n_reg[k];
                    sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
                end
            end
        end
    end

    always_comb
    begin
        rq   = sq_res_reg[SQ][24:1];
        rinc = sq_res_reg[SQ][0] & ((sq_n_reg[SQ] != 51'd0) | rq[0]);
        rsum = {1'b0, rq} + {24'd0, rinc};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_r_reg[0]    <= 25'h100_0000;
            dv_quot_reg[0] <= 25'd0;
            if (rsum[24])
            begin
                dv_q_reg[0] <= 24'h80_0000;
                dv_e_reg[0] <= sq_e_reg[SQ] + 10'd1;
            end
            else
            begin
                dv_q_reg[0] <= rsum[23:0];
                dv_e_reg[0] <= sq_e_reg[SQ];
            end
        end
    end

    for (genvar j = 0; j < DV; j++)
    begin : g_dv
        logic        ge;
        logic [24:0] dif;
        assign ge  = dv_r_reg[j] >= {1'b0, dv_q_reg[j]};
        assign dif = dv_r_reg[j] - {1'b0, dv_q_reg[j]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_q_reg[j+1]    <= dv_q_reg[j];
                dv_e_reg[j+1]    <= dv_e_reg[j];
                dv_quot_reg[j+1] <= {dv_quot_reg[j][23:0], ge};
                dv_r_reg[j+1]    <= ge ? {dif[23:0], 1'b0} : {dv_r_reg[j][23:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sb_reg[SB-1].spec) res_reg <= sb_reg[SB-1].val;
            else if (dv_q_reg[DV] == 24'h80_0000)
                res_reg <= {1'b0, 8'(10'd254 - dv_e_reg[DV]), 23'd0};
            else
                res_reg <= fpea_pkg::round_pack(1'b0, 10'd253 - dv_e_reg[DV],
                                                dv_quot_reg[DV][24:1], dv_quot_reg[DV][0],
                                                dv_r_reg[DV] != 25'd0);
        end
    end

    assign res = res_reg;

endmodule

// ----- test/fp32_elementwise_alu_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FP32 element-wise ALU testbench
// Drives operand words through every operation, register setting and special
// value class, with random gaps on both sides. Each result word is checked
// against a bit-exact prediction held in a queue.
// ----------------------------------------------------------------------------
module fp32_elementwise_alu_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 70;
    localparam int IDX_W = fpea_pkg::CFG_IDX_W;

    logic clk;
    logic rst_n;

    fpea_cfg_if cfg();
    fpea_in_if  din();
    fpea_out_if dout();

    fp32_elementwise_alu i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .din   (din.sink),
        .dout  (dout.source)
    );

    logic [2:0]  mode_reg;
    logic [31:0] scalar_reg;
    logic [31:0] pending_results[$];
    int          error_count;
    int          words_sent;
    int          words_checked;
    int          cycle_count;
    bit          gaps_enabled;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_nan32(input logic [31:0] b);
        return b[30:0] > fpea_pkg::INF_MAG;
    endfunction

    function automatic real fp32_to_real(input logic [31:0] b);
        logic [63:0] d;
        logic [22:0] m;
        int          e;
        m = b[22:0];
        if (b[30:23] == 8'hFF) d = {b[31], 11'h7FF, m, 29'd0};
        else if (b[30:23] == 8'd0)
        begin
            if (m == 23'd0) d = {b[31], 63'd0};
            else
            begin
                e = 1 - 127;
                while (!m[22])
                begin
                    m = m << 1;
                    e = e - 1;
                end
                m = m << 1;
                e = e - 1;
                d = {b[31], 11'(e + 1023), m, 29'd0};
            end
        end
        else d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), m, 29'd0};
        return $bitstoreal(d);
    endfunction

    // Round a double to fp32 with ties to even, keeping subnormals.
    function automatic logic [31:0] real_to_fp32(input real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] low_mask;
        int          fe;
        int          sh;
        bit          grd;
        bit          stk;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
        begin
            if (d[51:0] != 52'd0) return fpea_pkg::CANON_NAN;
            return {d[63], fpea_pkg::INF_MAG};
        end
        if (d[62:52] == 11'd0) return {d[63], 31'd0};
        fe = int'(d[62:52]) - 1023 + 127;
        if (fe >= 255) return {d[63], fpea_pkg::INF_MAG};
        sig = {11'd0, 1'b1, d[51:0]};
        sh = (fe >= 1) ? 29 : 29 + 1 - fe;
        if (sh > 60) sh = 60;
        q = sig >> sh;
        grd = sig[sh-1];
        low_mask = (64'd1 << (sh - 1)) - 64'd1;
        stk = (sig & low_mask) != 64'd0;
        if (grd && (stk || q[0])) q = q + 64'd1;
        if (fe >= 1)
        begin
            if (q == 64'h100_0000)
            begin
                q = 64'h80_0000;
                fe = fe + 1;
            end
            if (fe >= 255) return {d[63], fpea_pkg::INF_MAG};
            return {d[63], 8'(fe), q[22:0]};
        end
        return {d[63], q[30:0]};
    endfunction

    function automatic logic [31:0] root_of_positive(input logic [31:0] b);
        logic [31:0] m;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        logic [31:0] q;
        int          e;
        int          s;
        int          bexp;
        bit          grd;
        bit          stk;
        m = {9'd0, b[22:0]};
        if (b[30:23] == 8'd0)
        begin
            e = -149;
            while (m < 32'h80_0000)
            begin
                m = m << 1;
                e = e - 1;
            end
        end
        else
        begin
            m = m | 32'h80_0000;
            e = int'(b[30:23]) - 150;
        end
        s = ((e & 1) != 0) ? 25 : 26;
        n = 64'(m) << s;
        res = 64'd0;
        bitv = 64'd1 << 48;
        while (bitv != 64'd0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else res = res >> 1;
            bitv = bitv >> 2;
        end
        q = 32'(res >> 1);
        grd = res[0];
        stk = n != 64'd0;
        bexp = (e - s) / 2 + 151;
        if (grd && (stk || q[0]))
        begin
            q = q + 32'd1;
            if (q == 32'h100_0000)
            begin
                q = 32'h80_0000;
                bexp = bexp + 1;
            end
        end
        return {1'b0, 8'(bexp), q[22:0]};
    endfunction

    function automatic logic [31:0] recip_sqrt(input logic [31:0] a);
        if (is_nan32(a)) return fpea_pkg::CANON_NAN;
        if (a[30:0] == 31'd0) return {a[31], fpea_pkg::INF_MAG};
        if (a[31]) return fpea_pkg::CANON_NAN;
        if (a[30:0] == fpea_pkg::INF_MAG) return 32'd0;
        return real_to_fp32(1.0 / fp32_to_real(root_of_positive(a)));
    endfunction

    function automatic logic [31:0] predict_result(input logic [31:0] a, input logic [31:0] b);
        real ra;
        real rb;
        ra = fp32_to_real(a);
        rb = fp32_to_real(b);
        case (mode_reg)
            fpea_pkg::OP_ADDS: return real_to_fp32(ra + fp32_to_real(scalar_reg));
            fpea_pkg::OP_ADD:  return real_to_fp32(ra + rb);
            fpea_pkg::OP_SUB:  return real_to_fp32(ra - rb);
            fpea_pkg::OP_MAX:
            begin
                if (is_nan32(a) || is_nan32(b)) return a;
                return (ra < rb) ? b : a;
            end
            fpea_pkg::OP_MUL:  return real_to_fp32(ra * rb);
            fpea_pkg::OP_RSQ:  return recip_sqrt(a);
            default:           return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:0] = 31'd0;
            1: v[30:0] = fpea_pkg::INF_MAG;
            2: v[30:23] = 8'hFF;
            3: v[30:23] = 8'd0;
            4: v[30:23] = 8'($urandom_range(1, 30));
            5: v[30:23] = 8'($urandom_range(230, 254));
            6, 7: v[30:23] = 8'($urandom_range(115, 140));
            default: ;
        endcase
        return v;
    endfunction

    task automatic gap(input bit allowed);
        while (allowed && gaps_enabled && $urandom_range(0, 99) < 17)
        begin
            din.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_operands(input logic [31:0] a, input logic [31:0] b);
        gap(1'b1);
        din.valid     <= 1'b1;
        din.operand_a <= a;
        din.operand_b <= b;
        @(posedge clk);
        while (!din.ready) @(posedge clk);
        pending_results = {pending_results, predict_result(a, b)};
        words_sent++;
    endtask

    task automatic wait_empty();
        din.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        wait_empty();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        if (idx == fpea_pkg::CFG_OP_MODE) mode_reg = value[2:0];
        else if (idx == fpea_pkg::CFG_SCALAR) scalar_reg = value;
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic [2:0] m);
        write_register(fpea_pkg::CFG_OP_MODE, {29'($urandom_range(0, 32'h1FFF_FFFF)), m});
    endtask

    task automatic test_reset_mode();
        send_operands(32'h3F80_0000, 32'h4000_0000);
        send_operands(32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_operands(32'h0000_0001, 32'h8000_0001);
    endtask

    task automatic test_directed_specials();
        set_mode(fpea_pkg::OP_ADD);
        send_operands(32'h7F80_0000, 32'hFF80_0000);
        send_operands(32'h0040_0000, 32'h0040_0000);
        set_mode(fpea_pkg::OP_SUB);
        send_operands(32'h3F80_0001, 32'h3F80_0000);
        send_operands(32'h8000_0000, 32'h0000_0000);
        set_mode(fpea_pkg::OP_MAX);
        send_operands(32'h8000_0000, 32'h0000_0000);
        send_operands(32'h0000_0000, 32'h8000_0000);
        send_operands(32'h7FC1_2345, 32'h3F80_0000);
        send_operands(32'h3F80_0000, 32'hFF80_0001);
        send_operands(32'hBF80_0000, 32'h3F80_0000);
        set_mode(fpea_pkg::OP_MUL);
        send_operands(32'h7F80_0000, 32'h0000_0000);
        send_operands(32'h0000_0001, 32'h3F00_0000);
        send_operands(32'h7F7F_FFFF, 32'h4000_0000);
        set_mode(fpea_pkg::OP_RSQ);
        send_operands(32'h0000_0000, 32'hFFFF_FFFF);
        send_operands(32'h8000_0000, 32'h0);
        send_operands(32'h7F80_0000, 32'h0);
        send_operands(32'hFF80_0000, 32'h0);
        send_operands(32'hBF80_0000, 32'h0);
        send_operands(32'h0000_0001, 32'h0);
        send_operands(32'h4080_0000, 32'h0);
        send_operands(32'h7FFF_FFFF, 32'h0);
        write_register(fpea_pkg::CFG_SCALAR, 32'hFF7F_FFFF);
        set_mode(fpea_pkg::OP_ADDS);
        send_operands(32'hFF7F_FFFF, 32'h1234_5678);
        send_operands(32'h7F7F_FFFF, 32'h0);
    endtask

    task automatic test_unused_modes();
        set_mode(fpea_pkg::OP_RSV6);
        send_operands(32'h3F80_0000, 32'h3F80_0000);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_mode(fpea_pkg::OP_RSV7);
        send_operands(32'h4000_0000, 32'h0000_0000);
        send_operands(32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_ignored_index();
        logic [IDX_W-1:0] idx;
        set_mode(fpea_pkg::OP_ADDS);
        write_register(fpea_pkg::CFG_SCALAR, 32'h3F80_0000);
        idx = IDX_W'(2);
        write_register(idx, 32'hFFFF_FFFF);
        idx = IDX_W'(3);
        write_register(idx, 32'h0000_0004);
        send_operands(32'h4000_0000, 32'h0);
        send_operands(32'hBF80_0000, 32'h0);
    endtask

    task automatic test_random_mode(input logic [2:0] m, input int count);
        logic [31:0] a;
        logic [31:0] b;
        set_mode(m);
        for (int i = 0; i < count; i++)
        begin
            if (m == fpea_pkg::OP_ADDS && i % 40 == 0)
            begin
                write_register(fpea_pkg::CFG_SCALAR, pick_operand());
                set_mode(fpea_pkg::OP_ADDS);
            end
            a = pick_operand();
            b = pick_operand();
            if ($urandom_range(0, 3) == 0)
            begin
                b = a ^ 32'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1) b[31] = ~b[31];
            end
            if (m == fpea_pkg::OP_RSQ && $urandom_range(0, 4) != 0) a[31] = 1'b0;
            send_operands(a, b);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        din.valid     = 1'b0;
        din.operand_a = 32'd0;
        din.operand_b = 32'd0;
        dout.ready    = 1'b0;
        cfg.valid     = 1'b0;
        cfg.index     = fpea_pkg::CFG_OP_MODE;
        cfg.data      = 32'd0;
        mode_reg      = fpea_pkg::OP_ADD;
        scalar_reg    = 32'd0;
        error_count   = 0;
        words_sent    = 0;
        words_checked = 0;
        gaps_enabled  = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_mode();
        test_directed_specials();
        test_unused_modes();
        test_ignored_index();
        test_random_mode(fpea_pkg::OP_ADDS, 250);
        test_random_mode(fpea_pkg::OP_ADD, 250);
        gaps_enabled = 1'b0;
        test_random_mode(fpea_pkg::OP_SUB, 250);
        gaps_enabled = 1'b1;
        test_random_mode(fpea_pkg::OP_MAX, 250);
        test_random_mode(fpea_pkg::OP_MUL, 300);
        test_random_mode(fpea_pkg::OP_RSQ, 300);
        wait_empty();
        $display("Sent %0d operand words over all six operations, the unused modes and",
                 words_sent);
        $display("ignored register indices; %0d result words were checked.", words_checked);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        dout.ready <= (gaps_enabled && $urandom_range(0, 99) < 17) ? 1'b0 : 1'b1;
    end

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && dout.valid && dout.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result_value: expected none, actual %h", dout.result_value);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                words_checked++;
                if (dout.result_value !== want)
                begin
                    $error("result_value: expected %h, actual %h", want, dout.result_value);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
